// ===== rtl/fafd_pkg.sv =====
package fafd_pkg;

   localparam int DEF_NUM_FRAMES = 256;

   // register index of fit_mode on the csr_ port
   localparam logic [1:0] REG_FIT_MODE = 2'd0;

   typedef enum logic [1:0] {
      MODE_NEXT  = 2'd0,
      MODE_BEST  = 2'd1,
      MODE_WORST = 2'd2,
      MODE_SCAT  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_PLACED    = 2'd0,
      ST_COMPACTED = 2'd1,
      ST_SKIPPED   = 2'd2,
      ST_RELEASED  = 2'd3
   } status_type;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

endpackage

// ===== rtl/frame_allocator_fit_defrag_core.sv =====
// frame allocator core: one owner id per frame, held in a synchronous memory
// with one write and one read port, read-modify-write on a registered read.
// req_ channel: op, owner_id, frame_count; taken when req_valid && !req_stall.
// rsp_ channel: status, start_frame, frames_moved, free_frames, one result
// per request, held in an output register until taken (rsp_valid && !rsp_stall).
// csr_ port: one register, fit_mode, at address 0, APB-style, pready tied high.
// Steps after acceptance: a skipped request goes straight to its result;
// a release or non-contiguous placement is one sweep of all frames; a
// contiguous placement is a search of the frames (next fit stops at the first
// run that fits), then one write per frame placed and the result; a
// compaction adds a sweep that slides used frames down and a pass that
// clears the tail of free frames.
// Each pass steps through memory one frame a cycle; the next request is
// taken the cycle after the result is loaded.
// Reset clears the frame store by a pass over all frames while req_stall is high,
// clears the rover and sets fit_mode to next fit.
// A waiting result does not hold off the next request; a stalled receiver
// holds the block in its final step, and so req_stall, with the result in place.
module frame_allocator_fit_defrag_core
   import fafd_pkg::*;
#(
   parameter int NUM_FRAMES = DEF_NUM_FRAMES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_op,
   input  logic [7:0] req_owner_id,
   input  logic [8:0] req_frame_count,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_start_frame,
   output logic [8:0] rsp_frames_moved,
   output logic [8:0] rsp_free_frames,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = $clog2(NUM_FRAMES);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] NF = CW'(NUM_FRAMES);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_SCAN  = 7'b0000100,
      S_COMP  = 7'b0001000,
      S_CFILL = 7'b0010000,
      S_WRITE = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // frame store
   logic [7:0]    mem [NUM_FRAMES];
   logic [7:0]    rd_ff;
   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [7:0]    wdata;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   // config register
   logic [1:0] mode_ff;
   always_ff @(posedge clock) begin
      if (reset) mode_ff <= MODE_NEXT;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_FIT_MODE)
         mode_ff <= csr_pwdata[1:0];
   end
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_FIT_MODE) ? {30'd0, mode_ff} : 32'd0;

   // request and bookkeeping registers
   logic          op_ff;
   logic [7:0]    own_ff;
   logic [8:0]    cnt_ff;
   logic [CW-1:0] free_ff, free_in;
   logic [CW-1:0] rover_ff, rover_in;
   logic [CW-1:0] rq_ff, rq_in;      // read address counter
   logic [CW-1:0] pq_ff, pq_in;      // address of data in rd_ff
   logic          pv_ff, pv_in;      // rd_ff valid for scan
   logic [CW-1:0] run_ff, run_in;
   logic [CW-1:0] rs_ff, rs_in;      // current run start
   logic          fnd_ff, fnd_in;
   logic [CW-1:0] bst_ff, bst_in;    // chosen start
   logic [CW-1:0] bln_ff, bln_in;
   logic [CW-1:0] dst_ff, dst_in;
   logic [CW-1:0] mv_ff, mv_in;
   logic [CW-1:0] wq_ff, wq_in;
   logic [CW-1:0] given_ff, given_in;
   logic [1:0]    sts_ff, sts_in;
   logic          rv_ff, rv_in;
   logic [1:0]    osts_ff, osts_in;
   logic [7:0]    ostart_ff, ostart_in;
   logic [8:0]    omv_ff, omv_in, ofree_ff, ofree_in;

   wire accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         rover_ff <= '0;
         free_ff  <= NF;
         rq_ff    <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rover_ff <= rover_in;
         free_ff  <= free_in;
         rq_ff    <= rq_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      pq_ff <= pq_in; pv_ff <= pv_in; run_ff <= run_in; rs_ff <= rs_in;
      fnd_ff <= fnd_in; bst_ff <= bst_in; bln_ff <= bln_in; dst_ff <= dst_in;
      mv_ff <= mv_in; wq_ff <= wq_in; given_ff <= given_in; sts_ff <= sts_in;
      osts_ff <= osts_in; ostart_ff <= ostart_in; omv_ff <= omv_in;
      ofree_ff <= ofree_in;
      if (accept) begin
         op_ff <= req_op; own_ff <= req_owner_id; cnt_ff <= req_frame_count;
      end
   end

   // search helpers on the frame arriving from memory
   logic          is_free;
   logic [CW-1:0] run_nx, rs_nx, lim;
   logic          run_end, fits, better;

   always_comb begin
      state_in = state_ff; rover_in = rover_ff; free_in = free_ff;
      rq_in = rq_ff; pq_in = pq_ff; pv_in = 1'b0; run_in = run_ff;
      rs_in = rs_ff; fnd_in = fnd_ff; bst_in = bst_ff; bln_in = bln_ff;
      dst_in = dst_ff; mv_in = mv_ff; wq_in = wq_ff; given_in = given_ff;
      sts_in = sts_ff; rv_in = rv_ff; osts_in = osts_ff;
      ostart_in = ostart_ff; omv_in = omv_ff; ofree_in = ofree_ff;
      we = 1'b0; waddr = wq_ff[AW-1:0]; wdata = 8'd0;
      raddr = rq_ff[AW-1:0];
      is_free = (rd_ff == 8'd0);
      run_nx = is_free ? run_ff + 1'b1 : '0;
      rs_nx = (run_ff == '0) ? pq_ff : rs_ff;
      // next fit: first pass rover..top, second 0..rover (no run across wrap)
      lim = (mode_ff == MODE_NEXT) ? rover_ff : '0;
      run_end = (pq_ff == NF - 1'b1) || (pq_ff == lim - 1'b1 && lim != '0);
      fits = ({1'b0, run_nx} >= {1'b0, CW'(cnt_ff)});
      better = !fnd_ff || ((mode_ff == MODE_BEST) ? run_ff < bln_ff
                                                  : run_ff > bln_ff);
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            we = 1'b1; waddr = rq_ff[AW-1:0];
            rq_in = rq_ff + 1'b1;
            if (rq_ff == NF - 1'b1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               rq_in = (req_op == OP_ALLOC && mode_ff == MODE_NEXT) ? rover_ff : '0;
               if (rq_in == NF) rq_in = '0;
               run_in = '0; fnd_in = 1'b0; bln_in = '0; bst_in = '0;
               dst_in = '0; mv_in = '0; given_in = '0; wq_in = '0;
               sts_in = ST_PLACED;
               if (req_op == OP_RELEASE) begin
                  sts_in = ST_RELEASED;
                  state_in = S_WRITE;
               end else if (req_owner_id == 8'd0 || req_frame_count == 9'd0 ||
                            {1'b0, req_frame_count} > {1'b0, 9'(free_ff)}) begin
                  sts_in = ST_SKIPPED;
                  state_in = S_DONE;
               end else if (mode_ff == MODE_SCAT) begin
                  state_in = S_WRITE;
               end else begin
                  state_in = S_SCAN;
                  pv_in = 1'b0;
               end
               pq_in = rq_in;
            end
         end
         S_SCAN: begin
            // issue reads; rd_ff holds frame pq_ff in the cycle after its read
            pv_in = 1'b1;
            pq_in = rq_ff;
            rq_in = (rq_ff == NF - 1'b1) ? '0 : rq_ff + 1'b1;
            if (pv_ff) begin
               run_in = run_nx; rs_in = rs_nx;
               if (mode_ff == MODE_NEXT) begin
                  if (is_free && fits && !fnd_ff) begin
                     fnd_in = 1'b1; bst_in = rs_nx;
                  end
                  if (run_end) run_in = '0;
               end else begin
                  // close a hole at a used frame or at the top
                  if (!is_free && run_ff != '0 &&
                      {1'b0, run_ff} >= {1'b0, CW'(cnt_ff)} && better) begin
                     fnd_in = 1'b1; bst_in = rs_ff; bln_in = run_ff;
                  end
                  if (is_free && pq_ff == NF - 1'b1 && fits &&
                      (!fnd_ff || ((mode_ff == MODE_BEST) ? run_nx < bln_ff
                                                          : run_nx > bln_ff))) begin
                     fnd_in = 1'b1; bst_in = rs_nx; bln_in = run_nx;
                  end
                  if (pq_ff == NF - 1'b1) run_in = '0;
               end
               // the pass ends at the frame before the first one read, or at the first fit in next fit
               if (pq_ff == ((lim == '0 || mode_ff != MODE_NEXT) ? NF : lim) - 1'b1
                   || (mode_ff == MODE_NEXT && fnd_in)) begin
                  pv_in = 1'b0; rq_in = '0;
                  if (fnd_in) begin
                     wq_in = bst_in; state_in = S_WRITE;
                  end else begin
                     sts_in = ST_COMPACTED; state_in = S_COMP;
                  end
               end
            end
         end
         S_COMP: begin
            // slide used frames down; write lags read so dst <= read address
            pv_in = 1'b1; pq_in = rq_ff;
            if (rq_ff != NF) rq_in = rq_ff + 1'b1;
            raddr = rq_ff[AW-1:0];
            if (pv_ff && !is_free) begin
               we = 1'b1; waddr = dst_ff[AW-1:0]; wdata = rd_ff;
               dst_in = dst_ff + 1'b1;
               if (dst_ff != pq_ff) mv_in = mv_ff + 1'b1;
            end
            if (pv_ff && pq_ff == NF - 1'b1) begin
               pv_in = 1'b0; state_in = S_CFILL;
            end
         end
         S_CFILL: begin
            // clear the tail and place at the first free frame
            we = 1'b1; waddr = dst_ff[AW-1:0];
            dst_in = dst_ff + 1'b1;
            if (dst_ff == NF - 1'b1 || dst_in == NF) begin
               bst_in = NF - free_ff; wq_in = NF - free_ff; state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (op_ff == OP_RELEASE || mode_ff == MODE_SCAT) begin
               // read-modify-write sweep, write follows the registered read
               pv_in = 1'b1; pq_in = rq_ff;
               if (rq_ff != NF) rq_in = rq_ff + 1'b1;
               if (pv_ff) begin
                  we = 1'b1; waddr = pq_ff[AW-1:0]; wdata = rd_ff;
                  if (op_ff == OP_RELEASE) begin
                     if (rd_ff == own_ff && own_ff != 8'd0) begin
                        wdata = 8'd0; free_in = free_in + 1'b1;
                     end
                  end else if (is_free && given_ff < CW'(cnt_ff)) begin
                     wdata = own_ff; given_in = given_ff + 1'b1;
                     free_in = free_in - 1'b1;
                     if (given_ff == '0) bst_in = pq_ff;
                  end
                  if (pq_ff == NF - 1'b1) state_in = S_DONE;
               end
            end else begin
               we = 1'b1; waddr = wq_ff[AW-1:0]; wdata = own_ff;
               wq_in = wq_ff + 1'b1;
               if (wq_in == bst_ff + CW'(cnt_ff)) begin
                  free_in = free_ff - CW'(cnt_ff);
                  if (mode_ff == MODE_NEXT) rover_in = wq_in;
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1; osts_in = sts_ff;
               ostart_in = (sts_ff == ST_PLACED || sts_ff == ST_COMPACTED)
                           ? 8'(bst_ff) : 8'd0;
               omv_in = 9'(mv_ff); ofree_in = 9'(free_ff);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = osts_ff;
   assign rsp_start_frame = ostart_ff;
   assign rsp_frames_moved = omv_ff;
   assign rsp_free_frames = ofree_ff;

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("result changed while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall)
      else $error("request taken while busy");
   a_free: assert property (@(posedge clock) disable iff (reset)
      free_ff <= NF)
      else $error("free count out of range");
`endif

endmodule
